// ----- src/assert_macros.svh -----
// Assertion macros shared by the click event parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cel_pkg.sv -----
// Shared types and character constants for the click event line parser.
// No dependencies; used by every module of the block.
package cel_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_WS_LO   = 8'h09;
  localparam logic [7:0] CH_WS_HI   = 8'h0d;

  localparam int DIGIT_BITS  = 9;   // byte - '0' spans -48..207
  localparam int RADIX       = 10;
  localparam int QUEUE_DEPTH = 2;   // power of two
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic                         is_space;
    logic                         is_newline;
    logic                         is_minus;
    logic                         is_letter_c;
    logic signed [DIGIT_BITS-1:0] digit;
  } token_t;

endpackage

// ----- src/cel_front.sv -----
// Front end: classifies each received byte into a token.
// Depends on cel_pkg.
module cel_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     byte_in,
  output logic           tok_valid,
  input  logic           tok_ready,
  output cel_pkg::token_t tok
);
  import cel_pkg::*;

  assign tok_valid = in_valid;
  assign in_ready  = tok_ready;

  always_comb begin
    tok.is_space    = (byte_in == CH_BLANK) || (byte_in >= CH_WS_LO && byte_in <= CH_WS_HI);
    tok.is_newline  = (byte_in == CH_NEWLINE);
    tok.is_minus    = (byte_in == CH_MINUS);
    tok.is_letter_c = (byte_in == CH_C);
    tok.digit       = $signed({1'b0, byte_in}) - $signed({1'b0, CH_ZERO});
  end

endmodule

// ----- src/cel_queue.sv -----
// Short token queue between front and back; each side stalls on its own.
// Depends on cel_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cel_pkg::token_t push_tok,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cel_pkg::token_t pop_tok
);
  import cel_pkg::*;

  token_t               slot [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, count <= QCNT_BITS'(QUEUE_DEPTH), "queue count over depth")
  `ASSERT_CLK(a_push_grows, (push && !pop) |=> (count == $past(count) + 1'b1), "push lost")
  `ASSERT_CLK(a_pop_shrinks, (pop && !push) |=> (count == $past(count) - 1'b1), "pop lost")

endmodule

// ----- src/cel_back.sv -----
// Back end: line state machine, saturating accumulators, result register.
// Depends on cel_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cel_back #(
  parameter int FIELD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tok_valid,
  output logic                         tok_ready,
  input  cel_pkg::token_t              tok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_BITS-1:0] click_index,
  output logic signed [FIELD_BITS-1:0] click_button,
  output logic signed [FIELD_BITS-1:0] click_position
);
  import cel_pkg::*;

  localparam logic [2:0] PH_EVENT    = 3'd0;
  localparam logic [2:0] PH_CLICK    = 3'd1;
  localparam logic [2:0] PH_INDEX    = 3'd2;
  localparam logic [2:0] PH_BUTTON   = 3'd3;
  localparam logic [2:0] PH_POSITION = 3'd4;
  localparam logic [2:0] PH_INVALID  = 3'd5;

  localparam int WIDE = FIELD_BITS + 5;
  localparam logic signed [WIDE-1:0] WIDE_MAX = WIDE'((64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE-1:0] WIDE_MIN = -WIDE_MAX - WIDE'(1);
  localparam logic signed [FIELD_BITS-1:0] F_MAX = WIDE_MAX[FIELD_BITS-1:0];
  localparam logic signed [FIELD_BITS-1:0] F_MIN = WIDE_MIN[FIELD_BITS-1:0];

  logic [2:0]                   phase, phase_next;
  logic signed [FIELD_BITS-1:0] index_acc, index_acc_next;
  logic signed [FIELD_BITS-1:0] button_acc, button_acc_next;
  logic signed [FIELD_BITS-1:0] position_acc, position_acc_next;
  logic                         minus_seen, minus_seen_next;
  logic                         emit;

  logic signed [FIELD_BITS-1:0] sel_acc;
  logic signed [WIDE-1:0]       step_sum;
  logic signed [FIELD_BITS-1:0] step_sat;
  logic signed [FIELD_BITS-1:0] neg_sat;
  logic                         take;

  assign tok_ready = !out_valid || out_ready;
  assign take      = tok_valid && tok_ready;

  // One shared digit unit; only the active field's accumulator feeds it.
  always_comb begin
    case (phase)
      PH_INDEX:  sel_acc = index_acc;
      PH_BUTTON: sel_acc = button_acc;
      default:   sel_acc = position_acc;
    endcase
    step_sum = WIDE'(sel_acc) * WIDE'(RADIX) + WIDE'(tok.digit);
    if (step_sum > WIDE_MAX) begin
      step_sat = F_MAX;
    end else if (step_sum < WIDE_MIN) begin
      step_sat = F_MIN;
    end else begin
      step_sat = step_sum[FIELD_BITS-1:0];
    end
    neg_sat = (sel_acc == F_MIN) ? F_MAX : -sel_acc;
  end

  always_comb begin
    phase_next        = phase;
    index_acc_next    = index_acc;
    button_acc_next   = button_acc;
    position_acc_next = position_acc;
    minus_seen_next   = minus_seen;
    emit              = 1'b0;
    unique case (phase)
      PH_EVENT: begin
        if (!tok.is_space) phase_next = tok.is_letter_c ? PH_CLICK : PH_INVALID;
      end
      PH_CLICK: begin
        if (tok.is_space) begin
          index_acc_next    = '0;
          button_acc_next   = '0;
          position_acc_next = '0;
          minus_seen_next   = 1'b0;
          phase_next        = PH_INDEX;
        end
      end
      PH_INDEX: begin
        if (tok.is_minus) begin
          minus_seen_next = 1'b1;
        end else if (tok.is_space) begin
          if (minus_seen) index_acc_next = neg_sat;
          minus_seen_next = 1'b0;
          phase_next      = PH_BUTTON;
        end else begin
          index_acc_next = step_sat;
        end
      end
      PH_BUTTON: begin
        if (tok.is_minus) begin
          minus_seen_next = 1'b1;
        end else if (tok.is_space) begin
          if (minus_seen) button_acc_next = neg_sat;
          minus_seen_next = 1'b0;
          phase_next      = PH_POSITION;
        end else begin
          button_acc_next = step_sat;
        end
      end
      PH_POSITION: begin
        if (tok.is_minus) begin
          minus_seen_next = 1'b1;
        end else if (tok.is_newline) begin
          if (minus_seen) position_acc_next = neg_sat;
          phase_next = PH_EVENT;
          emit       = 1'b1;
        end else begin
          position_acc_next = step_sat;
        end
      end
      PH_INVALID: begin
        if (tok.is_newline) phase_next = PH_EVENT;
      end
      default: begin
        phase_next = PH_EVENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EVENT;
      index_acc    <= '0;
      button_acc   <= '0;
      position_acc <= '0;
      minus_seen   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        index_acc    <= index_acc_next;
        button_acc   <= button_acc_next;
        position_acc <= position_acc_next;
        minus_seen   <= minus_seen_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      click_index    <= index_acc;
      click_button   <= button_acc;
      click_position <= position_acc_next;
    end
  end

  `ASSERT_CLK(a_emit_loads, (take && emit) |=> out_valid, "result not loaded")
  `ASSERT_CLK(a_emit_from_position, (take && emit) |-> (phase == PH_POSITION),
              "result outside position field")
  `ASSERT_CLK(a_line_restart, (take && emit) |=> (phase == PH_EVENT), "no restart after result")

endmodule

// ----- src/click_event_line_parser_unit.sv -----
// Click event line parser, top level.
// Input channel: byte_in with in_valid/in_ready, one text byte per beat.
// Output channel: click_index, click_button, click_position with
//   out_valid/out_ready, one beat per completed click line.
// A line is 'c', a run of non-space bytes, whitespace, then index, button
// and position separated by whitespace, closed by newline. Other lines are
// dropped through their newline. Fields saturate to signed FIELD_BITS.
// Throughput: one byte per cycle while results are taken; the back end
//   updates with one shared multiply-by-ten, add and clamp.
// Result path: the closing newline beat passes through the token queue,
//   then the result register, before the result beat is valid.
// Reset (rst, synchronous): queue empties, parser waits for the event letter,
//   accumulators clear, no result is pending.
// Receiver stall: the result register holds; the back end stops while a
//   result waits, the 2-entry queue fills, then in_ready drops. Nothing is
//   lost or repeated.
// Depends on cel_pkg, cel_front, cel_queue, cel_back.
module click_event_line_parser_unit #(
  parameter int FIELD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   byte_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_BITS-1:0] click_index,
  output logic signed [FIELD_BITS-1:0] click_button,
  output logic signed [FIELD_BITS-1:0] click_position
);
  import cel_pkg::*;

  // Front -> queue
  logic   front_valid;
  logic   front_ready;
  token_t front_tok;
  // Queue -> back
  logic   back_valid;
  logic   back_ready;
  token_t back_tok;

  // Byte classification: whitespace, newline, minus, 'c', digit value.
  cel_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .tok_valid (front_valid),
    .tok_ready (front_ready),
    .tok       (front_tok)
  );

  // Decouples byte intake from the parser so a stalled result does not
  // stop intake at once.
  cel_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_tok   (front_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_tok    (back_tok)
  );

  // Line state machine, accumulators and the result register.
  cel_back #(
    .FIELD_BITS (FIELD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .tok_valid      (back_valid),
    .tok_ready      (back_ready),
    .tok            (back_tok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .click_index    (click_index),
    .click_button   (click_button),
    .click_position (click_position)
  );

endmodule

// ----- verif/click_event_line_parser_unit_tb.sv -----
// Self-checking bench for click_event_line_parser_unit: text bytes in, click beats out.
// Needs cel_pkg and the parser RTL. The expected clicks come from a behavioral parser
// that runs alongside the driver.
`timescale 1ns / 100ps

module click_event_line_parser_unit_tb;
  import cel_pkg::*;

  localparam int FIELD_BITS   = 16;
  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int IDLE_PCT     = 34;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  // Parser position within a line, tracked by the behavioral model.
  typedef enum logic [2:0] {
    AWAIT_EVENT,
    SKIP_NAME,
    READ_INDEX,
    READ_BUTTON,
    READ_POSITION,
    DROP_LINE
  } line_phase_e;

  typedef struct {
    field_t index;
    field_t button;
    field_t position;
  } click_t;

  // One pending input beat; drain holds it back until every click has come out,
  // calm marks the stretch where neither side idles.
  typedef struct {
    logic [7:0] data;
    bit         drain;
    bit         calm;
  } byte_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         in_valid  = 1'b0;
  logic         in_ready;
  logic [7:0]   byte_in   = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  field_t       click_index;
  field_t       click_button;
  field_t       click_position;

  byte_beat_t   tx_bytes[$];
  click_t       clicks_due[$];
  logic         calm_now    = 1'b0;
  bit           hold_next   = 1'b0;
  bit           calm_fill   = 1'b0;
  int           error_count = 0;
  int           cycle_count = 0;

  // Behavioral parser state.
  line_phase_e  phase;
  field_t       idx_acc;
  field_t       btn_acc;
  field_t       pos_acc;
  logic         neg_flag;

  click_event_line_parser_unit #(
    .FIELD_BITS(FIELD_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_in       (byte_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .click_index   (click_index),
    .click_button  (click_button),
    .click_position(click_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral parser
  // ---------------------------------------------------------------------------

  // Whitespace is TAB..CR and blank; high bytes are not whitespace.
  function automatic bit is_ws(input logic [7:0] b);
    return b == CH_BLANK || (b >= CH_WS_LO && b <= CH_WS_HI);
  endfunction

  function automatic field_t clamp_field(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (FIELD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return field_t'(hi);
    if (v < lo) return field_t'(lo);
    return field_t'(v);
  endfunction

  // Any byte is taken in with its code minus '0', so letters and blanks land
  // outside 0..9 and may pull the value negative.
  function automatic field_t shift_in(input field_t acc, input logic [7:0] b);
    return clamp_field(longint'(acc) * RADIX + (longint'(b) - longint'(CH_ZERO)));
  endfunction

  // Negating the negative rail saturates to the positive rail.
  function automatic field_t flip_sign(input field_t v);
    return clamp_field(-longint'(v));
  endfunction

  task automatic clear_parser();
    phase    = AWAIT_EVENT;
    idx_acc  = '0;
    btn_acc  = '0;
    pos_acc  = '0;
    neg_flag = 1'b0;
  endtask

  // Advance the model by one accepted byte; a closed position queues a click.
  task automatic parse_beat(input logic [7:0] b);
    click_t done;
    case (phase)
      AWAIT_EVENT: begin
        if (!is_ws(b)) phase = (b == CH_C) ? SKIP_NAME : DROP_LINE;
      end
      SKIP_NAME: begin
        if (is_ws(b)) begin
          idx_acc  = '0;
          btn_acc  = '0;
          pos_acc  = '0;
          neg_flag = 1'b0;
          phase    = READ_INDEX;
        end
      end
      READ_INDEX: begin
        if (b == CH_MINUS) begin
          neg_flag = 1'b1;
        end else if (is_ws(b)) begin
          if (neg_flag) idx_acc = flip_sign(idx_acc);
          neg_flag = 1'b0;
          phase    = READ_BUTTON;
        end else begin
          idx_acc = shift_in(idx_acc, b);
        end
      end
      READ_BUTTON: begin
        if (b == CH_MINUS) begin
          neg_flag = 1'b1;
        end else if (is_ws(b)) begin
          if (neg_flag) btn_acc = flip_sign(btn_acc);
          neg_flag = 1'b0;
          phase    = READ_POSITION;
        end else begin
          btn_acc = shift_in(btn_acc, b);
        end
      end
      READ_POSITION: begin
        // only newline closes the position; the sign flag survives the line end
        if (b == CH_MINUS) begin
          neg_flag = 1'b1;
        end else if (b == CH_NEWLINE) begin
          if (neg_flag) pos_acc = flip_sign(pos_acc);
          phase         = AWAIT_EVENT;
          done.index    = idx_acc;
          done.button   = btn_acc;
          done.position = pos_acc;
          clicks_due.push_back(done);
        end else begin
          pos_acc = shift_in(pos_acc, b);
        end
      end
      DROP_LINE: begin
        if (b == CH_NEWLINE) phase = AWAIT_EVENT;
      end
      default: begin
        phase = AWAIT_EVENT;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic push_beat(input logic [7:0] b);
    byte_beat_t beat;
    beat.data  = b;
    beat.drain = hold_next;
    beat.calm  = calm_fill;
    hold_next  = 1'b0;
    tx_bytes.push_back(beat);
  endtask

  function automatic logic [7:0] pick_ws();
    int n;
    n = $urandom_range(5);
    return (n == 5) ? CH_BLANK : CH_WS_LO + 8'(n);
  endfunction

  function automatic logic [7:0] pick_solid();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_ws(b));
    return b;
  endfunction

  // A field body: mostly short decimals, some long enough to hit a rail, some
  // made of odd bytes; now and then a '-' at any spot.
  task automatic push_number(input bit is_pos);
    int         mode;
    int         len;
    int         sign_at;
    logic [7:0] ch;
    mode    = $urandom_range(9);
    len     = (mode < 6) ? $urandom_range(3) : $urandom_range(7, 5);
    sign_at = ($urandom_range(3) == 0) ? $urandom_range(len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == sign_at) push_beat(CH_MINUS);
      if (mode < 8) begin
        ch = CH_ZERO + 8'($urandom_range(9));
      end else begin
        do ch = 8'($urandom_range(255));
        while (ch == CH_MINUS || (is_pos ? ch == CH_NEWLINE : is_ws(ch)));
      end
      push_beat(ch);
    end
    if (sign_at == len) push_beat(CH_MINUS);
  endtask

  task automatic push_click_line();
    int n;
    n = $urandom_range(2);
    repeat (n) push_beat(pick_ws());
    push_beat(CH_C);
    n = $urandom_range(3);
    repeat (n) push_beat(pick_solid());
    push_beat(pick_ws());
    push_number(1'b0);
    push_beat(pick_ws());
    push_number(1'b0);
    push_beat(pick_ws());
    push_number(1'b1);
    push_beat(CH_NEWLINE);
  endtask

  task automatic push_dropped_line();
    logic [7:0] b;
    int         n;
    do b = pick_solid(); while (b == CH_C);
    push_beat(b);
    n = $urandom_range(6);
    repeat (n) begin
      do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
      push_beat(b);
    end
    push_beat(CH_NEWLINE);
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) push_beat(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string what);
    $display("ERROR t=%0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_click();
    click_t want;
    if (clicks_due.size() == 0) begin
      flag_error($sformatf("click %0d %0d %0d with none pending",
                           click_index, click_button, click_position));
    end else begin
      want = clicks_due.pop_front();
      if (click_index !== want.index)
        flag_error($sformatf("index %0d, want %0d", click_index, want.index));
      if (click_button !== want.button)
        flag_error($sformatf("button %0d, want %0d", click_button, want.button));
      if (click_position !== want.position)
        flag_error($sformatf("position %0d, want %0d", click_position, want.position));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat from tx_bytes at a time. The model advances on the edge
  // that accepts a beat. A new beat is loaded only when the slot is free, so
  // in_valid gets a single update per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      byte_in  <= '0;
      calm_now <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && in_ready) parse_beat(byte_in);
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 &&
            (tx_bytes[0].calm || $urandom_range(99) >= IDLE_PCT) &&
            !(tx_bytes[0].drain && clicks_due.size() != 0)) begin
          byte_in  <= tx_bytes[0].data;
          calm_now <= tx_bytes[0].calm;
          in_valid <= 1'b1;
          void'(tx_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted click beat and stalls the output at random,
  // except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_click();
      out_ready <= calm_now || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] opening[];
    int         pick;
    int         stop_at;

    opening = '{
      // dropped line: opens with NUL, carries a high byte
      8'h00, 8'hff, CH_NEWLINE,
      // leading TAB and blank skipped, high byte in the event name, VT separator
      CH_WS_LO, CH_BLANK, CH_C, 8'hff, 8'h0b,
      // index: NULs pull it onto the negative rail, the sign flips it to the
      // positive rail, CR closes it
      8'h00, 8'h00, 8'h00, 8'h00, CH_MINUS, CH_WS_HI,
      // button -9, form feed closes it
      CH_MINUS, "9", 8'h0c,
      // position: 7, the blank is taken in (54), then the sign gives -54
      "7", CH_BLANK, CH_MINUS, CH_NEWLINE,
      // index overflows to the positive rail, newline as separator, minus zero
      CH_C, CH_NEWLINE, "9", "9", "9", "9", "9", CH_BLANK, "0", 8'h0b,
      CH_MINUS, CH_NEWLINE
    };
    foreach (opening[i]) push_beat(opening[i]);

    // Random part; its first beat waits for the directed clicks to drain.
    hold_next = 1'b1;
    stop_at   = tx_bytes.size() + RANDOM_BYTES;
    while (tx_bytes.size() < stop_at) begin
      calm_fill = tx_bytes.size() >= 700 && tx_bytes.size() < 1000;
      if ($urandom_range(29) == 0) hold_next = 1'b1;
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_click_line();
      end else if (pick < 85) begin
        push_dropped_line();
      end else begin
        push_noise();
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (clicks_due.size() != 0) @(posedge clk);
    // result path runs through the queue and result register; leave room for a stray beat
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
